// ===== rtl/sfd_pkg.sv =====
package sfd_pkg;

  // Width used to hold a clamped image dimension (covers up to 4096).
  localparam int DIM_W = 13;
  // Width of a configuration register.
  localparam int CFG_W = 11;
  // Smallest image dimension the block works with.
  localparam int MIN_DIM = 3;

  // Reset values of the configuration registers.
  localparam logic [CFG_W-1:0] RESET_WIDTH  = 11'd640;
  localparam logic [CFG_W-1:0] RESET_HEIGHT = 11'd480;

  // Register indexes, taken from address bit 2.
  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  // Gradient response, square and sum widths.
  localparam int GRAD_W = 11;
  localparam int SQ_W   = 20;
  localparam int PROD_W = 22;
  localparam int SUM_W  = 22;

  // Sums at or above this value give a root of 255.
  localparam logic [SUM_W-1:0] ROOT_SAT = 22'd65025;

  // Cap applied to the squares and to the product.
  localparam int CAP = 255;

  // Per-pixel sequencer.
  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_GRAD,
    S_MUL,
    S_SUM,
    S_ROOT
  } seq_state_t;

endpackage

// ===== rtl/sfd_ram.sv =====
module sfd_ram
  #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
  )
  (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
  );

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/sfd_sqrt.sv =====
module sfd_sqrt
  import sfd_pkg::*;
  (
    input  logic             clk,
    input  logic             rst,
    input  logic             start,
    input  logic [SUM_W-1:0] operand,
    output logic             busy,
    output logic [7:0]       root
  );

  logic        sat;
  logic [15:0] rem_val;
  logic [7:0]  acc;
  logic [7:0]  mask;
  logic [7:0]  trial;
  logic [15:0] trial_sq;

  // One result bit per cycle, most significant first.
  assign trial    = acc | mask;
  assign trial_sq = trial * trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && mask[0]) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sat     <= (operand >= ROOT_SAT);
      rem_val <= operand[15:0];
      acc     <= 8'd0;
      mask    <= 8'h80;
    end else if (busy) begin
      if (trial_sq <= rem_val) begin
        acc <= trial;
      end
      mask <= mask >> 1;
    end
  end

  // Large sums saturate to the top code.
  assign root = sat ? 8'hFF : acc;

endmodule

// ===== rtl/sobel_four_direction_edge.sv =====
// Four-direction Sobel edge detector for 8-bit grey pixels in raster order.
// Input channel: in_valid / in_ready carrying pixel. Output channel:
// out_valid / out_ready carrying magnitude, gx_squared, gx_gy_product,
// gy_squared, center_row and center_col. One word is given for every pixel
// whose 3x3 window centre lies off the image border; border pixels give none.
// Image width and height are set through the APB port (addresses 0 and 4)
// and should only be changed while the block is idle.
// Sequence: a pixel that gives no result passes only the accept and the line
// store read; an interior pixel then goes on through the gradient, multiply
// and sum stages and the eight-step square root unit, after which its
// result word is loaded into the output register.
// The output register holds a finished word while the next pixel is taken
// in; if the receiver stalls and that register is still full when the next
// root is ready, the block waits and in_ready stays low.
// Reset clears the position counters, the sequencer and the output valid,
// and restores width 640 and height 480. Line stores are not cleared.
module sobel_four_direction_edge
  import sfd_pkg::*;
  #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
  )
  (
    input  logic                     clk,
    input  logic                     rst,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [2:0]               paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [7:0]               pixel,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [7:0]               magnitude,
    output logic [7:0]               gx_squared,
    output logic signed [20:0]       gx_gy_product,
    output logic [7:0]               gy_squared,
    output logic [9:0]               center_row,
    output logic [9:0]               center_col
  );

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);

  seq_state_t state, state_next;

  logic [CFG_W-1:0] image_width;
  logic [CFG_W-1:0] image_height;
  logic [DIM_W-1:0] eff_width;
  logic [DIM_W-1:0] eff_height;

  logic [CW-1:0] column_count;
  logic [RW-1:0] row_count;
  logic [CW-1:0] col_q;
  logic [RW-1:0] row_q;
  logic [7:0]    pixel_q;
  logic          emit;

  logic          in_fire;
  logic          cfg_write;
  logic          ram_we;
  logic [7:0]    upper_rdata;
  logic [7:0]    middle_rdata;

  logic [7:0]    win [3][3];

  logic signed [11:0] a, b, c, d, f, g, h, k;
  logic signed [11:0] gx_c, gy_c, ga_c, gb_c;
  logic signed [GRAD_W-1:0] gx_r, gy_r, ga_r, gb_r;

  logic signed [PROD_W-1:0] xx_p, yy_p, aa_p, bb_p, xy_p;
  logic [SQ_W-1:0]          sq_x, sq_y, sq_a, sq_b;
  logic signed [PROD_W-1:0] xy_r;
  logic [SUM_W-1:0]         sum_c;

  logic          root_start;
  logic          root_busy;
  logic [7:0]    root;
  logic          out_load;

  logic [CW-1:0] col_m1;
  logic [RW-1:0] row_m1;
  logic [CW+9:0] col_wide;
  logic [RW+9:0] row_wide;

  // Configuration port.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= RESET_WIDTH;
      image_height <= RESET_HEIGHT;
    end else if (cfg_write) begin
      if (paddr[2] == REG_IMAGE_WIDTH) begin
        image_width <= pwdata[CFG_W-1:0];
      end else begin
        image_height <= pwdata[CFG_W-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == REG_IMAGE_HEIGHT) begin
      prdata = {{(32-CFG_W){1'b0}}, image_height};
    end else begin
      prdata = {{(32-CFG_W){1'b0}}, image_width};
    end
  end

  // Clamp the dimensions to the supported range.
  always_comb begin
    if (image_width < CFG_W'(MIN_DIM)) begin
      eff_width = DIM_W'(MIN_DIM);
    end else if (DIM_W'(image_width) > DIM_W'(MAX_WIDTH)) begin
      eff_width = DIM_W'(MAX_WIDTH);
    end else begin
      eff_width = DIM_W'(image_width);
    end
    if (image_height < CFG_W'(MIN_DIM)) begin
      eff_height = DIM_W'(MIN_DIM);
    end else if (DIM_W'(image_height) > DIM_W'(MAX_HEIGHT)) begin
      eff_height = DIM_W'(MAX_HEIGHT);
    end else begin
      eff_height = DIM_W'(image_height);
    end
  end

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and control strobes.
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    ram_we     = 1'b0;
    root_start = 1'b0;
    out_load   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        ram_we     = 1'b1;
        state_next = emit ? S_GRAD : S_IDLE;
      end
      S_GRAD: begin
        state_next = S_MUL;
      end
      S_MUL: begin
        state_next = S_SUM;
      end
      S_SUM: begin
        root_start = 1'b1;
        state_next = S_ROOT;
      end
      S_ROOT: begin
        if (!root_busy && (!out_valid || out_ready)) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign in_fire = in_valid && in_ready;

  // Position counters advance as each pixel is accepted.
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (in_fire) begin
      if (DIM_W'(column_count) + DIM_W'(1) >= eff_width) begin
        column_count <= '0;
        if (DIM_W'(row_count) + DIM_W'(1) >= eff_height) begin
          row_count <= '0;
        end else begin
          row_count <= row_count + 1'b1;
        end
      end else begin
        column_count <= column_count + 1'b1;
      end
    end
  end

  // Capture the pixel and its position.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      pixel_q <= pixel;
      col_q   <= column_count;
      row_q   <= row_count;
      emit    <= (row_count >= RW'(2)) && (column_count >= CW'(2));
    end
  end

  // Line stores: read on accept, written back in the next cycle, from the read state.
  sfd_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_upper (
    .clk   (clk),
    .we    (ram_we),
    .waddr (col_q),
    .wdata (middle_rdata),
    .re    (in_fire),
    .raddr (column_count),
    .rdata (upper_rdata)
  );

  sfd_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_middle (
    .clk   (clk),
    .we    (ram_we),
    .waddr (col_q),
    .wdata (pixel_q),
    .re    (in_fire),
    .raddr (column_count),
    .rdata (middle_rdata)
  );

  // Slide the window one column and load the new right column.
  always_ff @(posedge clk) begin
    if (state == S_READ) begin
      for (int r = 0; r < 3; r++) begin
        win[r][0] <= win[r][1];
        win[r][1] <= win[r][2];
      end
      win[0][2] <= upper_rdata;
      win[1][2] <= middle_rdata;
      win[2][2] <= pixel_q;
    end
  end

  // Kernel responses.
  always_comb begin
    a = $signed({4'b0, win[0][0]});
    b = $signed({4'b0, win[0][1]});
    c = $signed({4'b0, win[0][2]});
    d = $signed({4'b0, win[1][0]});
    f = $signed({4'b0, win[1][2]});
    g = $signed({4'b0, win[2][0]});
    h = $signed({4'b0, win[2][1]});
    k = $signed({4'b0, win[2][2]});
    gx_c = (c + f + f + k) - (a + d + d + g);
    gy_c = (a + b + b + c) - (g + h + h + k);
    ga_c = b + c + c - d + f - g - g - h;
    gb_c = f + h + k + k - a - a - b - d;
  end

  always_ff @(posedge clk) begin
    if (state == S_GRAD) begin
      gx_r <= gx_c[GRAD_W-1:0];
      gy_r <= gy_c[GRAD_W-1:0];
      ga_r <= ga_c[GRAD_W-1:0];
      gb_r <= gb_c[GRAD_W-1:0];
    end
  end

  // Squares and the cross product.
  assign xx_p = gx_r * gx_r;
  assign yy_p = gy_r * gy_r;
  assign aa_p = ga_r * ga_r;
  assign bb_p = gb_r * gb_r;
  assign xy_p = gx_r * gy_r;

  always_ff @(posedge clk) begin
    if (state == S_MUL) begin
      sq_x <= xx_p[SQ_W-1:0];
      sq_y <= yy_p[SQ_W-1:0];
      sq_a <= aa_p[SQ_W-1:0];
      sq_b <= bb_p[SQ_W-1:0];
      xy_r <= xy_p;
    end
  end

  // Sum of the four squares feeds the root unit.
  assign sum_c = SUM_W'(sq_x) + SUM_W'(sq_y) + SUM_W'(sq_a) + SUM_W'(sq_b);

  sfd_sqrt u_sqrt (
    .clk     (clk),
    .rst     (rst),
    .start   (root_start),
    .operand (sum_c),
    .busy    (root_busy),
    .root    (root)
  );

  // Centre position, taken to ten bits.
  assign col_m1   = col_q - 1'b1;
  assign row_m1   = row_q - 1'b1;
  assign col_wide = {10'b0, col_m1};
  assign row_wide = {10'b0, row_m1};

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      magnitude     <= root;
      gx_squared    <= (sq_x > SQ_W'(CAP)) ? 8'hFF : sq_x[7:0];
      gy_squared    <= (sq_y > SQ_W'(CAP)) ? 8'hFF : sq_y[7:0];
      gx_gy_product <= (xy_r > PROD_W'(CAP)) ? 21'sd255 : xy_r[20:0];
      center_row    <= row_wide[9:0];
      center_col    <= col_wide[9:0];
    end
  end

endmodule

// ===== rtl/sfd_checker.sv =====
module sfd_checker
  import sfd_pkg::*;
  (
    input logic              clk,
    input logic              rst,
    input logic              in_valid,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input logic [7:0]        magnitude,
    input logic [7:0]        gx_squared,
    input logic signed [20:0] gx_gy_product,
    input logic [7:0]        gy_squared,
    input logic [9:0]        center_row,
    input logic [9:0]        center_col
  );

  // After reset the block is empty and ready for a pixel.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("block not empty after reset");

  // A pixel is never followed by another in the very next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("pixel accepted back to back");

  // A new word is loaded as the sequencer returns to idle.
  a_ready_on_load: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> in_ready)
    else $error("sequencer busy when word was loaded");

  // The product is capped above.
  a_product_cap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> gx_gy_product <= 21'sd255)
    else $error("product above cap");

  // A stalled word holds.
  a_word_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(magnitude)
      && $stable(center_row) && $stable(center_col))
    else $error("stalled word changed");

endmodule

bind sobel_four_direction_edge sfd_checker u_sfd_checker (.*);

// ===== test/tb_top.sv =====
module tb_top;
  import sfd_pkg::*;

  localparam int MAX_W = 1024;
  localparam int MAX_H = 1024;
  // Largest value the squares, the product and the root may take.
  localparam int EDGE_CAP = 255;
  // Idle time left after the last edge word, so a pixel that gives no edge word can finish.
  localparam int SETTLE_CYCLES = 20;
  localparam int RUN_LIMIT = 15_000_000;

  typedef enum int {
    PIX_NOISE,
    PIX_BINARY,
    PIX_SMOOTH,
    PIX_RAMP
  } pixel_style_t;

  typedef struct {
    logic [7:0]         magnitude;
    logic [7:0]         gx_squared;
    logic signed [20:0] gx_gy_product;
    logic [7:0]         gy_squared;
    logic [9:0]         center_row;
    logic [9:0]         center_col;
  } edge_word_t;

  logic               clk = 1'b0;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [2:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid;
  logic               in_ready;
  logic [7:0]         pixel;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [7:0]         magnitude;
  logic [7:0]         gx_squared;
  logic signed [20:0] gx_gy_product;
  logic [7:0]         gy_squared;
  logic [9:0]         center_row;
  logic [9:0]         center_col;

  // Own copy of the image geometry and the pixel history.
  logic [CFG_W-1:0] width_reg = RESET_WIDTH;
  logic [CFG_W-1:0] height_reg = RESET_HEIGHT;
  bit [7:0]         upper_line [MAX_W];
  bit [7:0]         middle_line [MAX_W];
  bit [7:0]         win [3][3];
  int unsigned      col_pos = 0;
  int unsigned      row_pos = 0;

  edge_word_t  pending_edges [$];
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned pixels_sent = 0;
  int unsigned edges_checked = 0;
  int unsigned frame_settings = 0;
  int unsigned error_count = 0;

  sobel_four_direction_edge #(
    .MAX_WIDTH  (MAX_W),
    .MAX_HEIGHT (MAX_H)
  ) u_dut (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .pixel         (pixel),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .magnitude     (magnitude),
    .gx_squared    (gx_squared),
    .gx_gy_product (gx_gy_product),
    .gy_squared    (gy_squared),
    .center_row    (center_row),
    .center_col    (center_col)
  );

  always #5 clk = ~clk;

  // The receiver stalls at random, at the rate of the current phase.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // A dimension register is clamped into the range the block supports.
  function automatic int unsigned clamp_dim(input logic [CFG_W-1:0] v, input int unsigned hi);
    if (v < MIN_DIM) return MIN_DIM;
    if (v > hi) return hi;
    return v;
  endfunction

  // Shift one pixel into the window and work out the edge word, if any.
  function automatic bit sobel_window_step(input logic [7:0] px, output edge_word_t w);
    int unsigned eff_w;
    int unsigned eff_h;
    int a, b, c, d, f, g, h, k;
    int gx, gy, ga, gb, xx, xy, yy;
    int unsigned total;
    int unsigned root;
    bit [7:0] up;
    bit [7:0] mid;
    bit produced;
    eff_w = clamp_dim(width_reg, MAX_W);
    eff_h = clamp_dim(height_reg, MAX_H);
    up = upper_line[col_pos];
    mid = middle_line[col_pos];
    upper_line[col_pos] = mid;
    middle_line[col_pos] = px;
    for (int r = 0; r < 3; r++) begin
      win[r][0] = win[r][1];
      win[r][1] = win[r][2];
    end
    win[0][2] = up;
    win[1][2] = mid;
    win[2][2] = px;
    produced = (row_pos >= 2) && (col_pos >= 2);
    if (produced) begin
      a = win[0][0]; b = win[0][1]; c = win[0][2];
      d = win[1][0]; f = win[1][2];
      g = win[2][0]; h = win[2][1]; k = win[2][2];
      gx = (c + 2 * f + k) - (a + 2 * d + g);
      gy = (a + 2 * b + c) - (g + 2 * h + k);
      ga = b + 2 * c - d + f - 2 * g - h;
      gb = -2 * a - b - d + f + h + 2 * k;
      total = gx * gx + gy * gy + ga * ga + gb * gb;
      root = 0;
      if (total >= EDGE_CAP * EDGE_CAP) begin
        root = EDGE_CAP;
      end else begin
        while ((root + 1) * (root + 1) <= total) root++;
      end
      xx = (gx * gx > EDGE_CAP) ? EDGE_CAP : gx * gx;
      xy = (gx * gy > EDGE_CAP) ? EDGE_CAP : gx * gy;
      yy = (gy * gy > EDGE_CAP) ? EDGE_CAP : gy * gy;
      w.magnitude = root[7:0];
      w.gx_squared = xx[7:0];
      w.gx_gy_product = xy[20:0];
      w.gy_squared = yy[7:0];
      w.center_row = 10'(row_pos - 1);
      w.center_col = 10'(col_pos - 1);
    end
    // Advance the raster position; a counter past a new limit wraps next.
    if (col_pos + 1 >= eff_w) begin
      col_pos = 0;
      row_pos = (row_pos + 1 >= eff_h) ? 0 : row_pos + 1;
    end else begin
      col_pos = col_pos + 1;
    end
    return produced;
  endfunction

  function automatic logic [7:0] make_pixel(input pixel_style_t style, input int unsigned base);
    case (style)
      PIX_BINARY: return $urandom_range(1) ? 8'hFF : 8'h00;
      PIX_SMOOTH: return 8'(base % 240 + $urandom_range(8));
      PIX_RAMP: return 8'(base + 3 * col_pos + 5 * row_pos + $urandom_range(2));
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // Offer one pixel, after a random gap, and record the word it should give.
  task automatic send_pixel(input logic [7:0] px);
    edge_word_t w;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    pixel <= px;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (sobel_window_step(px, w)) pending_edges = {pending_edges, w};
    pixels_sent++;
  endtask

  // Stop sending and wait until every edge word has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_edges.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One APB transfer; the upper data bits carry noise the register ignores.
  task automatic apb_transfer(input logic is_write, input logic reg_sel,
                              input logic [CFG_W-1:0] value, output logic [31:0] rdata);
    logic [31:0] noise;
    noise = $urandom();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= is_write;
    paddr <= {reg_sel, 2'b00};
    pwdata <= {noise[31:CFG_W], value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    // Leave the bus idle between transfers.
    @(posedge clk);
  endtask

  task automatic check_register(input logic reg_sel, input logic [CFG_W-1:0] expected);
    logic [31:0] readback;
    apb_transfer(1'b0, reg_sel, '0, readback);
    if (readback !== {{(32 - CFG_W){1'b0}}, expected}) begin
      $error("%s: expected %0d, actual %0d",
             (reg_sel == REG_IMAGE_WIDTH) ? "image_width" : "image_height",
             expected, readback);
      error_count++;
    end
  endtask

  task automatic set_dimension(input logic reg_sel, input logic [CFG_W-1:0] value);
    logic [31:0] unused;
    apb_transfer(1'b1, reg_sel, value, unused);
    if (reg_sel == REG_IMAGE_WIDTH) width_reg = value;
    else height_reg = value;
    check_register(reg_sel, value);
  endtask

  // Compare each edge word with the oldest one predicted.
  always @(posedge clk) begin : check_edges
    edge_word_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_edges.size() == 0) begin
        $error("edge word for row %0d col %0d arrived with none expected",
               center_row, center_col);
        error_count++;
      end else begin
        want = pending_edges.pop_front();
        edges_checked++;
        if (magnitude !== want.magnitude) begin
          $error("magnitude: expected %0d, actual %0d", want.magnitude, magnitude);
          error_count++;
        end
        if (gx_squared !== want.gx_squared) begin
          $error("gx_squared: expected %0d, actual %0d", want.gx_squared, gx_squared);
          error_count++;
        end
        if (gx_gy_product !== want.gx_gy_product) begin
          $error("gx_gy_product: expected %0d, actual %0d",
                 want.gx_gy_product, gx_gy_product);
          error_count++;
        end
        if (gy_squared !== want.gy_squared) begin
          $error("gy_squared: expected %0d, actual %0d", want.gy_squared, gy_squared);
          error_count++;
        end
        if (center_row !== want.center_row) begin
          $error("center_row: expected %0d, actual %0d", want.center_row, center_row);
          error_count++;
        end
        if (center_col !== want.center_col) begin
          $error("center_col: expected %0d, actual %0d", want.center_col, center_col);
          error_count++;
        end
      end
    end
  end

  // Both registers must come out of reset at the default VGA geometry.
  task automatic test_reset_values();
    check_register(REG_IMAGE_WIDTH, RESET_WIDTH);
    check_register(REG_IMAGE_HEIGHT, RESET_HEIGHT);
  endtask

  // A 5x5 frame with full-scale steps, a flat area and faint detail, so the
  // root saturates, the product goes strongly negative and the borders stay
  // silent.
  task automatic test_directed_window();
    logic [0:24][7:0] frame_px;
    frame_px = {8'd255, 8'd255, 8'd255, 8'd0,  8'd0,
                8'd255, 8'd255, 8'd255, 8'd0,  8'd0,
                8'd0,   8'd0,   8'd0,   8'd0,  8'd0,
                8'd0,   8'd0,   8'd0,   8'd10, 8'd12,
                8'd0,   8'd7,   8'd0,   8'd11, 8'd13};
    set_dimension(REG_IMAGE_WIDTH, 11'd5);
    set_dimension(REG_IMAGE_HEIGHT, 11'd5);
    frame_settings++;
    for (int i = 0; i < 25; i++) send_pixel(frame_px[i]);
    wait_drained();
  endtask

  // Register values below the minimum, which the block treats as the
  // smallest image.
  task automatic test_dimension_limits();
    // Zero and one clamp to the smallest image; a gentle ramp keeps every
    // response small.
    set_dimension(REG_IMAGE_WIDTH, 11'd0);
    set_dimension(REG_IMAGE_HEIGHT, 11'd1);
    for (int i = 0; i < 9; i++) send_pixel(8'(100 + i % 3));
    wait_drained();
    set_dimension(REG_IMAGE_WIDTH, 11'd2);
    set_dimension(REG_IMAGE_HEIGHT, 11'd2);
    for (int i = 0; i < 9; i++) send_pixel(make_pixel(PIX_NOISE, 0));
    wait_drained();
    frame_settings += 2;
  endtask

  // Random frames of mostly small sizes and mixed textures. Some frames stop
  // part way, wait for the block to empty and then may change a dimension.
  task automatic test_random_frames(input int unsigned items, input int unsigned send_pct,
                                    input int unsigned recv_pct);
    int unsigned goal;
    int unsigned frame_len;
    int unsigned stop_at;
    int unsigned base;
    int unsigned ew;
    logic [CFG_W-1:0] fw;
    logic [CFG_W-1:0] fh;
    pixel_style_t style;
    bit fresh;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    goal = pixels_sent + items;
    fresh = 1'b1;
    while (pixels_sent < goal) begin
      if (fresh || $urandom_range(3) != 0) begin
        wait_drained();
        case ($urandom_range(11))
          0: begin
            fw = 11'($urandom_range(0, 2));
            fh = 11'($urandom_range(0, 5));
          end
          1: begin
            fw = 11'($urandom_range(25, 64));
            fh = 11'($urandom_range(3, 6));
          end
          default: begin
            fw = 11'($urandom_range(3, 16));
            fh = 11'($urandom_range(3, 9));
          end
        endcase
        set_dimension(REG_IMAGE_WIDTH, fw);
        set_dimension(REG_IMAGE_HEIGHT, fh);
        frame_settings++;
        fresh = 1'b0;
      end
      style = pixel_style_t'($urandom_range(3));
      base = $urandom_range(255);
      frame_len = clamp_dim(width_reg, MAX_W) * clamp_dim(height_reg, MAX_H);
      stop_at = ($urandom_range(4) == 0) ? $urandom_range(1, frame_len - 1) : frame_len;
      for (int n = 0; n < stop_at; n++) send_pixel(make_pixel(style, base));
      if (stop_at < frame_len) begin
        // Hold off until every word is out, then possibly resize mid-frame.
        wait_drained();
        ew = clamp_dim(width_reg, MAX_W);
        case ($urandom_range(2))
          0: set_dimension(REG_IMAGE_HEIGHT, 11'($urandom_range(3, 9)));
          1: if (ew > MIN_DIM) set_dimension(REG_IMAGE_WIDTH, 11'($urandom_range(MIN_DIM, ew - 1)));
          default: ;
        endcase
        while (col_pos != 0 || row_pos != 0) send_pixel(make_pixel(style, base));
      end
    end
    wait_drained();
  endtask

  initial begin
    rst <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    in_valid <= 1'b0;
    pixel <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_reset_values();
    send_idle_pct = 35;
    recv_idle_pct = 77;
    test_directed_window();
    test_dimension_limits();
    test_random_frames(600, 35, 77);
    test_random_frames(600, 77, 35);
    test_random_frames(590, 0, 0);
    wait_drained();
    $display("Checked %0d edge words from %0d pixels over %0d image settings.",
             edges_checked, pixels_sent, frame_settings);
    $display("Sizes ran from 3x3 up to 64 wide, with clamped registers, stalls and resizes.");
    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #(RUN_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
